### design/ple_pkg.sv
// Package for the positional list engine: transaction types, operation codes,
// status codes and default sizes. No dependencies.
`default_nettype none
package ple_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 6;
	localparam int COUNT_W      = 6;

	// Requested operation
	typedef enum logic [2:0] {
		KIND_INS_FRONT = 3'd0,
		KIND_INS_BACK  = 3'd1,
		KIND_INS_AT    = 3'd2,
		KIND_DEL_FRONT = 3'd3,
		KIND_DEL_BACK  = 3'd4,
		KIND_DEL_AT    = 3'd5,
		KIND_READ      = 3'd6,
		KIND_NOP       = 3'd7
	} kind_t;

	// Outcome of an operation
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// What every cell does in a cycle
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} ctl_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} in_t;

	typedef struct packed {
		status_t                   status;
		logic [COUNT_W-1:0]        count;
		logic signed [VALUE_W-1:0] element;
		logic                      element_valid;
		logic                      last;
	} out_t;

endpackage
`default_nettype wire

### design/ple_cell.sv
// One storage cell of the list chain; takes data from its neighbours.
// Depends on ple_pkg.
`default_nettype none
module ple_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  wire                                 clk,
	input  wire ple_pkg::ctl_t                  ctl,
	input  wire [CW-1:0]                        idx,
	input  wire [CW-1:0]                        tail,
	input  wire signed [ple_pkg::VALUE_W-1:0]   value,
	input  wire signed [ple_pkg::VALUE_W-1:0]   left,
	input  wire signed [ple_pkg::VALUE_W-1:0]   right,
	input  wire signed [ple_pkg::VALUE_W-1:0]   head,
	output logic signed [ple_pkg::VALUE_W-1:0]  data_q
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic signed [ple_pkg::VALUE_W-1:0] data_d;

	// Pick the next value from the broadcast operation and this cell's place
	always_comb begin
		data_d = data_q;
		case (ctl.op)
			ple_pkg::OP_INSERT: begin
				if (MY_IDX == idx) begin
					data_d = value;
				end else if (MY_IDX > idx) begin
					data_d = left;
				end
			end
			ple_pkg::OP_DELETE: begin
				if (MY_IDX >= idx) begin
					data_d = right;
				end
			end
			ple_pkg::OP_ROTATE: begin
				if (MY_IDX == tail) begin
					data_d = head;
				end else if (MY_IDX < tail) begin
					data_d = right;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// Hold the value
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule
`default_nettype wire

### design/positional_list_engine_unit.sv
// Positional list engine top level: control, result register and cell chain.
// Depends on ple_pkg and ple_cell.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a row of
// shifting cells, front at cell 0. Every insert, delete or no-op transaction
// gives one result transaction carrying status and the new count. A read out
// gives one result per stored element, front first, with the final one marked
// last; the chain rotates one place a cycle past cell 0, the only read-out tap,
// whenever the result register is free, and input is held off until the
// rotation is complete and the list is back in place. A read of an empty
// list gives one result with status empty. Results pass through an output
// register, so a new transaction is taken while a result still waits, as long
// as that register is free to take the next one.
`default_nettype none
module positional_list_engine_unit #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  wire ple_pkg::in_t in_data,
	output logic           out_valid,
	input  wire            out_ready,
	output ple_pkg::out_t  out_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t                             state_q;
	logic [CW-1:0]                      cnt_q;
	logic [CW-1:0]                      rd_q;
	logic                               out_valid_q;
	ple_pkg::out_t                      out_q;

	logic                               out_free;
	logic                               accept;
	logic                               full;
	logic                               empty;
	logic [WW-1:0]                      pos_w;
	logic [WW-1:0]                      cnt_w;
	logic [CW-1:0]                      pos_idx;
	logic [CW-1:0]                      tail;
	logic                               go_read;
	logic                               read_step;
	logic                               read_last;
	ple_pkg::status_t                   status_d;
	logic [CW-1:0]                      cnt_d;
	logic [CW-1:0]                      idx;
	ple_pkg::ctl_t                      ctl;
	logic signed [ple_pkg::VALUE_W-1:0] cell_q [CAPACITY];

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign full      = (cnt_q == CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign pos_w     = WW'(in_data.position);
	assign cnt_w     = WW'(cnt_q);
	assign pos_idx   = CW'(in_data.position - ple_pkg::POS_W'(1));
	assign tail      = cnt_q - CW'(1);
	assign read_step = (state_q == ST_READ) && out_free;
	assign read_last = (rd_q == tail);

	// Decode the transaction into a chain operation, status and new count
	always_comb begin
		ctl.op   = ple_pkg::OP_HOLD;
		idx      = '0;
		status_d = ple_pkg::STAT_DONE;
		cnt_d    = cnt_q;
		go_read  = 1'b0;
		if (read_step) begin
			ctl.op = ple_pkg::OP_ROTATE;
		end else if (accept) begin
			case (in_data.kind)
				ple_pkg::KIND_INS_FRONT, ple_pkg::KIND_INS_BACK,
				ple_pkg::KIND_INS_AT: begin
					if (full) begin
						status_d = ple_pkg::STAT_FULL;
					end else if (in_data.kind == ple_pkg::KIND_INS_FRONT) begin
						ctl.op = ple_pkg::OP_INSERT;
						idx    = '0;
						cnt_d  = cnt_q + CW'(1);
					end else if (in_data.kind == ple_pkg::KIND_INS_BACK) begin
						ctl.op = ple_pkg::OP_INSERT;
						idx    = cnt_q;
						cnt_d  = cnt_q + CW'(1);
					end else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
						status_d = ple_pkg::STAT_RANGE;
					end else begin
						ctl.op = ple_pkg::OP_INSERT;
						idx    = pos_idx;
						cnt_d  = cnt_q + CW'(1);
					end
				end
				ple_pkg::KIND_DEL_FRONT, ple_pkg::KIND_DEL_BACK,
				ple_pkg::KIND_DEL_AT: begin
					if (empty) begin
						status_d = ple_pkg::STAT_EMPTY;
					end else if (in_data.kind == ple_pkg::KIND_DEL_FRONT) begin
						ctl.op = ple_pkg::OP_DELETE;
						idx    = '0;
						cnt_d  = tail;
					end else if (in_data.kind == ple_pkg::KIND_DEL_BACK) begin
						ctl.op = ple_pkg::OP_DELETE;
						idx    = tail;
						cnt_d  = tail;
					end else if (pos_w == '0 || pos_w > cnt_w) begin
						status_d = ple_pkg::STAT_RANGE;
					end else begin
						ctl.op = ple_pkg::OP_DELETE;
						idx    = pos_idx;
						cnt_d  = tail;
					end
				end
				ple_pkg::KIND_READ: begin
					if (empty) begin
						status_d = ple_pkg::STAT_EMPTY;
					end else begin
						go_read = 1'b1;
					end
				end
				default: begin
					status_d = ple_pkg::STAT_DONE;
				end
			endcase
		end
	end

	// Hold state, count, read-out position and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			case (state_q)
				ST_IDLE: begin
					if (go_read) begin
						state_q <= ST_READ;
						rd_q    <= '0;
					end
				end
				ST_READ: begin
					if (read_step) begin
						rd_q <= rd_q + CW'(1);
						if (read_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Raise valid on a new result, drop it once the result is taken
			if ((accept && !go_read) || read_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (read_step) begin
			out_q.status        <= ple_pkg::STAT_DONE;
			out_q.count         <= ple_pkg::COUNT_W'(cnt_q);
			out_q.element       <= cell_q[0];
			out_q.element_valid <= 1'b1;
			out_q.last          <= read_last;
		end else if (accept && !go_read) begin
			out_q.status        <= status_d;
			out_q.count         <= ple_pkg::COUNT_W'(cnt_d);
			out_q.element       <= '0;
			out_q.element_valid <= 1'b0;
			out_q.last          <= 1'b1;
		end
	end

	// Build the chain of cells, front at cell 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [ple_pkg::VALUE_W-1:0] left;
		logic signed [ple_pkg::VALUE_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = cell_q[i];
		end else begin : g_mid_l
			assign left = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_final
			assign right = cell_q[i];
		end else begin : g_mid_r
			assign right = cell_q[i+1];
		end

		ple_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.idx    (idx),
			.tail   (tail),
			.value  (in_data.value),
			.left   (left),
			.right  (right),
			.head   (cell_q[0]),
			.data_q (cell_q[i])
		);
	end

endmodule
`default_nettype wire

### test/tb_positional_list_engine_unit.sv
// Self-checking testbench for positional_list_engine_unit: a queued driver, a
// result monitor with an in-line list predictor, and a stall watchdog.
// Depends on ple_pkg and the engine RTL only.
module tb_positional_list_engine_unit;
	import ple_pkg::*;

	localparam int LIST_CAP   = CAPACITY_DEF;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// Transactions waiting to be offered, and results still owed by the engine
	in_t pending_ops[$];
	out_t expected_results[$];

	// Predicted list contents and length
	logic signed [VALUE_W-1:0] list_cells[LIST_CAP];
	int list_len = 0;

	// Length tally used while building stimulus
	int gen_len = 0;

	int ops_queued = 0;
	int ops_accepted = 0;
	int results_seen = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int quiet_cycles = 0;

	positional_list_engine_unit #(.CAPACITY(LIST_CAP)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Apply one operation to the predicted list and queue the results it owes
	task automatic apply_list_op(input in_t op);
		out_t res;
		int idx;
		int i;
		bit is_read;
		res = '0;
		res.status = STAT_DONE;
		res.last = 1'b1;
		is_read = 1'b0;
		case (op.kind)
			KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
				if (list_len >= LIST_CAP) begin
					res.status = STAT_FULL;
				end else if (op.kind == KIND_INS_AT &&
						(op.position < 1 || int'(op.position) > list_len + 1)) begin
					res.status = STAT_RANGE;
				end else begin
					if (op.kind == KIND_INS_FRONT)
						idx = 0;
					else if (op.kind == KIND_INS_BACK)
						idx = list_len;
					else
						idx = int'(op.position) - 1;
					for (i = list_len; i > idx; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[idx] = op.value;
					list_len++;
				end
			end
			KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
				if (list_len == 0) begin
					res.status = STAT_EMPTY;
				end else if (op.kind == KIND_DEL_AT &&
						(op.position < 1 || int'(op.position) > list_len)) begin
					res.status = STAT_RANGE;
				end else begin
					if (op.kind == KIND_DEL_FRONT)
						idx = 0;
					else if (op.kind == KIND_DEL_BACK)
						idx = list_len - 1;
					else
						idx = int'(op.position) - 1;
					for (i = idx; i + 1 < list_len; i++)
						list_cells[i] = list_cells[i+1];
					list_len--;
				end
			end
			KIND_READ: begin
				if (list_len == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					is_read = 1'b1;
					for (i = 0; i < list_len; i++) begin
						res.count = COUNT_W'(list_len);
						res.element = list_cells[i];
						res.element_valid = 1'b1;
						res.last = (i == list_len - 1);
						expected_results.push_back(res);
					end
				end
			end
			default: ;
		endcase
		if (!is_read) begin
			res.count = COUNT_W'(list_len);
			expected_results.push_back(res);
		end
	endtask

	// Queue one transaction and keep the stimulus-side length in step
	task automatic queue_op(input kind_t k, input logic signed [VALUE_W-1:0] v,
			input logic [POS_W-1:0] p);
		in_t op;
		op.kind = k;
		op.value = v;
		op.position = p;
		if (k == KIND_INS_FRONT || k == KIND_INS_BACK || k == KIND_INS_AT) begin
			if (gen_len < LIST_CAP && (k != KIND_INS_AT || (p >= 1 && int'(p) <= gen_len + 1)))
				gen_len++;
		end else if (k == KIND_DEL_FRONT || k == KIND_DEL_BACK || k == KIND_DEL_AT) begin
			if (gen_len > 0 && (k != KIND_DEL_AT || (p >= 1 && int'(p) <= gen_len)))
				gen_len--;
		end
		pending_ops.push_back(op);
		ops_queued++;
	endtask

	// Queue random transactions in episodes that grow, shrink or churn the list
	task automatic queue_random_ops(input int total);
		int left;
		int ep_len;
		int ep_no;
		int j;
		int r;
		int ins_pct;
		int del_pct;
		kind_t k;
		logic [POS_W-1:0] p;
		logic signed [VALUE_W-1:0] v;
		left = total;
		ep_no = $urandom_range(2);
		while (left > 0) begin
			ep_len = $urandom_range(20, 45);
			case (ep_no % 3)
				0: begin ins_pct = 85; del_pct = 5; end
				1: begin ins_pct = 10; del_pct = 75; end
				default: begin ins_pct = 42; del_pct = 42; end
			endcase
			ep_no++;
			for (j = 0; j < ep_len && left > 0; j++) begin
				r = $urandom_range(99);
				if (r < ins_pct)
					k = kind_t'($urandom_range(2));
				else if (r < ins_pct + del_pct)
					k = kind_t'(3 + $urandom_range(2));
				else if (r < 97)
					k = KIND_READ;
				else
					k = KIND_NOP;
				if ($urandom_range(99) < 85) begin
					if (k == KIND_INS_AT)
						p = POS_W'($urandom_range(1, gen_len + 1));
					else
						p = POS_W'($urandom_range(1, (gen_len > 0) ? gen_len : 1));
				end else begin
					p = POS_W'($urandom_range(63));
				end
				case ($urandom_range(9))
					0: v = 32'sh7fffffff;
					1: v = 32'sh80000000;
					2: v = '0;
					3: v = -32'sd1;
					default: v = $urandom();
				endcase
				queue_op(k, v, p);
				left--;
			end
		end
	endtask

	// Driver: offer queued transactions, hold each until it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_list_op(in_data);
				ops_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_ops.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result against the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result status %0d count %0d element %0h last %0b",
						$time, out_data.status, out_data.count, out_data.element, out_data.last);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status,
							out_data.status);
						mismatches++;
					end
					if (out_data.count !== want.count) begin
						$display("%0t: count expected %0d, got %0d", $time, want.count,
							out_data.count);
						mismatches++;
					end
					if (out_data.element !== want.element) begin
						$display("%0t: element expected %0h, got %0h", $time, want.element,
							out_data.element);
						mismatches++;
					end
					if (out_data.element_valid !== want.element_valid) begin
						$display("%0t: element_valid expected %0b, got %0b", $time,
							want.element_valid, out_data.element_valid);
						mismatches++;
					end
					if (out_data.last !== want.last) begin
						$display("%0t: last expected %0b, got %0b", $time, want.last,
							out_data.last);
						mismatches++;
					end
				end
			end
			// hold off once for a long stretch so the engine backs up into its input
			if (!long_hold_done && results_seen >= 30) begin
				hold_left = 200;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0)
				hold_left--;
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: give up when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct <= 0; recv_stall_pct <= 0; end
				1: begin send_idle_pct <= 65; recv_stall_pct <= 0; end
				2: begin send_idle_pct <= 0; recv_stall_pct <= 65; end
				default: begin send_idle_pct <= 20; recv_stall_pct <= 20; end
			endcase
			if (ph == 0) begin
				// empty list: every delete and read reports empty
				queue_op(KIND_DEL_FRONT, 32'sd5, 6'd1);
				queue_op(KIND_DEL_BACK, 32'sd5, 6'd1);
				queue_op(KIND_DEL_AT, 32'sd5, 6'd0);
				queue_op(KIND_READ, 32'sd0, 6'd0);
				// insert positions just outside and at the ends of the valid range
				queue_op(KIND_INS_AT, 32'sd1, 6'd0);
				queue_op(KIND_INS_AT, 32'sd1, 6'd2);
				queue_op(KIND_INS_AT, 32'sh7fffffff, 6'd1);
				queue_op(KIND_INS_FRONT, 32'sh80000000, 6'd0);
				queue_op(KIND_INS_BACK, -32'sd1, 6'd63);
				queue_op(KIND_INS_AT, 32'sd0, 6'd4);
				queue_op(KIND_INS_AT, 32'sd9, 6'd63);
				queue_op(KIND_INS_AT, 32'sh55555555, 6'd2);
				queue_op(KIND_READ, 32'sd0, 6'd0);
				// delete positions just outside and at the ends of the valid range
				queue_op(KIND_DEL_AT, 32'sd0, 6'd0);
				queue_op(KIND_DEL_AT, 32'sd0, 6'd6);
				queue_op(KIND_DEL_AT, 32'sd0, 6'd5);
				queue_op(KIND_DEL_AT, 32'sd0, 6'd1);
				queue_op(KIND_NOP, 32'shdeadbeef, 6'd42);
				queue_op(KIND_DEL_FRONT, 32'sd0, 6'd0);
				queue_op(KIND_DEL_BACK, 32'sd0, 6'd0);
				queue_op(KIND_READ, 32'sd0, 6'd0);
				queue_op(KIND_DEL_AT, 32'sd0, 6'd1);
				queue_op(KIND_READ, 32'sd0, 6'd0);
				queue_op(KIND_INS_BACK, 32'shaaaaaaaa, 6'd0);
				queue_random_ops(100);
			end else begin
				queue_random_ops(116);
			end
			// pause the sender until every owed result has come back
			while (!(ops_accepted == ops_queued && expected_results.size() == 0))
				@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### positional_list_engine_unit.f
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine_unit.sv
test/tb_positional_list_engine_unit.sv
